### rtl/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the euler to quaternion unit
// cordic angle table, gain, widths, the unit clamp and the q30 multiply helper
// ---------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W           = 32;
  localparam int QUAT_W            = 32;
  localparam int ANGLE_FRAC_BITS_D = 16;
  localparam int CORDIC_STEPS      = 30;
  localparam int CW                = 34;   // cordic datapath width
  localparam int IDX_W             = 5;

  localparam logic signed [CW-1:0] Q30_ONE     = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [QUAT_W-1:0] q30_t;

  function automatic cw_t atan_turn(input logic [IDX_W-1:0] i);
    cw_t t;
    unique case (i)
      5'd0:  t = CW'(34'h020000000);
      5'd1:  t = CW'(34'h012E4051E);
      5'd2:  t = CW'(34'h009FB385B);
      5'd3:  t = CW'(34'h0051111D4);
      5'd4:  t = CW'(34'h0028B0D43);
      5'd5:  t = CW'(34'h00145D7E1);
      5'd6:  t = CW'(34'h000A2F61E);
      5'd7:  t = CW'(34'h000517C55);
      5'd8:  t = CW'(34'h00028BE53);
      5'd9:  t = CW'(34'h000145F2F);
      5'd10: t = CW'(34'h0000A2F98);
      5'd11: t = CW'(34'h0000517CC);
      5'd12: t = CW'(34'h000028BE6);
      5'd13: t = CW'(34'h0000145F3);
      5'd14: t = CW'(34'h00000A2FA);
      5'd15: t = CW'(34'h00000517D);
      5'd16: t = CW'(34'h0000028BE);
      5'd17: t = CW'(34'h00000145F);
      5'd18: t = CW'(34'h000000A30);
      5'd19: t = CW'(34'h000000518);
      5'd20: t = CW'(34'h00000028C);
      5'd21: t = CW'(34'h000000146);
      5'd22: t = CW'(34'h0000000A3);
      5'd23: t = CW'(34'h000000051);
      5'd24: t = CW'(34'h000000029);
      5'd25: t = CW'(34'h000000014);
      5'd26: t = CW'(34'h00000000A);
      5'd27: t = CW'(34'h000000005);
      5'd28: t = CW'(34'h000000003);
      5'd29: t = CW'(34'h000000001);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic cw_t clamp_unit(input logic signed [CW:0] v);
    cw_t r;
    if (v > (CW+1)'(Q30_ONE)) begin
      r = Q30_ONE;
    end else if (v < -(CW+1)'(Q30_ONE)) begin
      r = -Q30_ONE;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  // q30 product rounded to nearest, ties up; operands within +-2^30
  function automatic cw_t qmul(input cw_t a, input cw_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (2*CW)'(64'sd536870912);
    return CW'(p >>> 30);
  endfunction

endpackage

### rtl/e2q_phase.sv
// ---------------------------------------------------------------------------
// e2q_phase: angle reduction and phase conversion
// truncated modulo 360 degrees, then half angle in 2^-32 turns, with fold
// ---------------------------------------------------------------------------
module e2q_phase #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_D
) (
  input  logic                                 clk,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle,
  output logic signed [e2q_pkg::CW-1:0]        phase,
  output logic                                 flip
);
  import e2q_pkg::*;

  localparam int FULL_W  = 9 + ANGLE_FRAC_BITS + 1;
  localparam longint FULL = 64'sd360 << ANGLE_FRAC_BITS;
  localparam int SH      = 28 - ANGLE_FRAC_BITS;
  // floor(r/45) for r < 2^FULL_W: reciprocal ceil(2^K3/45)
  localparam int K3      = FULL_W + 6;
  localparam int R3_W    = FULL_W + 1;
  localparam longint RECIP3 = ((64'sd1 << K3) + 44) / 45;
  // rounding of the leftover (v << SH) + 22 below 2^SW: reciprocal ceil(2^K5/45)
  localparam int SW      = 6 + SH;
  localparam int K5      = SW + 6;
  localparam longint RECIP5 = ((64'sd1 << K5) + 44) / 45;

  // stage 1: magnitude, sign and quotient estimate of |a| / 360
  logic                  neg1;
  logic [ANGLE_W-1:0]    mag1;
  logic [ANGLE_W-1:0]    quo1;
  logic [ANGLE_W-1:0]    mag_a;
  logic [63:0]           qprod;

  assign mag_a = angle[ANGLE_W-1] ? ANGLE_W'(-$signed({angle[ANGLE_W-1], angle}))
                                  : ANGLE_W'(angle);
  // floor(m/FULL) via truncated reciprocal: estimate is low by at most one
  localparam longint RFULL = (64'sd1 << 48) / FULL;
  assign qprod = 64'(mag_a) * 64'(RFULL);

  always_ff @(posedge clk) begin
    neg1 <= angle[ANGLE_W-1];
    mag1 <= mag_a;
    quo1 <= ANGLE_W'(qprod >> 48);
  end

  // stage 2: remainder with one correction
  logic                neg2;
  logic [FULL_W-1:0]   rem2;
  logic [63:0]         r_raw;
  logic [63:0]         qf;

  assign qf    = 64'(quo1) * 64'(FULL);
  assign r_raw = 64'(mag1) - qf;

  always_ff @(posedge clk) begin
    neg2 <= neg1;
    rem2 <= (r_raw >= 64'(FULL)) ? FULL_W'(r_raw - 64'(FULL)) : FULL_W'(r_raw);
  end

  // stage 3: u = floor(r / 45)
  logic                      neg3;
  logic [FULL_W-1:0]         rem3;
  logic [FULL_W-1:0]         quo3;
  logic [FULL_W+R3_W-1:0]    q3prod;

  assign q3prod = (FULL_W+R3_W)'(rem2) * (FULL_W+R3_W)'(RECIP3);

  always_ff @(posedge clk) begin
    neg3 <= neg2;
    rem3 <= rem2;
    quo3 <= FULL_W'(q3prod >> K3);
  end

  // stage 4: leftover v = r - 45u, below 45
  logic                neg4;
  logic [FULL_W-1:0]   quo4;
  logic [5:0]          res4;
  logic [FULL_W-1:0]   q45;

  assign q45 = quo3 * FULL_W'(45);

  always_ff @(posedge clk) begin
    neg4 <= neg3;
    quo4 <= quo3;
    res4 <= 6'(rem3 - q45);
  end

  // stage 5: p = (u << SH) + round((v << SH) / 45)
  logic                neg5;
  logic [CW-1:0]       pq5;
  logic [SW-1:0]       small5;
  logic [2*SW:0]       p5prod;

  assign small5 = (SW'(res4) << SH) + SW'(22);
  assign p5prod = (2*SW+1)'(small5) * (2*SW+1)'(RECIP5);

  always_ff @(posedge clk) begin
    neg5 <= neg4;
    pq5  <= (CW'(quo4) << SH) + CW'(p5prod >> K5);
  end

  // stage 6: sign and fold into +-2^30
  logic signed [CW:0] ps;
  assign ps = neg5 ? -(CW+1)'(pq5) : (CW+1)'(pq5);

  always_ff @(posedge clk) begin
    if (ps > (CW+1)'(Q30_ONE)) begin
      phase <= CW'(ps - (CW+1)'(64'sd2147483648));
      flip  <= 1'b1;
    end else if (ps < -(CW+1)'(Q30_ONE)) begin
      phase <= CW'(ps + (CW+1)'(64'sd2147483648));
      flip  <= 1'b1;
    end else begin
      phase <= CW'(ps);
      flip  <= 1'b0;
    end
  end

endmodule

### rtl/e2q_cordic.sv
// ---------------------------------------------------------------------------
// e2q_cordic: pipelined rotation-mode cordic, one stage per iteration
// gives clamped sine and cosine of the phase
// ---------------------------------------------------------------------------
module e2q_cordic (
  input  logic                          clk,
  input  logic signed [e2q_pkg::CW-1:0] phase,
  input  logic                          flip,
  output logic signed [e2q_pkg::CW-1:0] sin_q,
  output logic signed [e2q_pkg::CW-1:0] cos_q
);
  import e2q_pkg::*;

  cw_t xs [CORDIC_STEPS+1];
  cw_t ys [CORDIC_STEPS+1];
  cw_t zs [CORDIC_STEPS+1];
  logic fl [CORDIC_STEPS+1];

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = phase;
  assign fl[0] = flip;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      fl[i+1] <= fl[i];
      if (!zs[i][CW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_turn(IDX_W'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_turn(IDX_W'(i));
      end
    end
  end

  logic signed [CW:0] xf, yf;
  assign xf = fl[CORDIC_STEPS] ? -(CW+1)'(xs[CORDIC_STEPS]) : (CW+1)'(xs[CORDIC_STEPS]);
  assign yf = fl[CORDIC_STEPS] ? -(CW+1)'(ys[CORDIC_STEPS]) : (CW+1)'(ys[CORDIC_STEPS]);

  always_ff @(posedge clk) begin
    cos_q <= clamp_unit(xf);
    sin_q <= clamp_unit(yf);
  end

endmodule

### rtl/e2q_merge.sv
// ---------------------------------------------------------------------------
// e2q_merge: combines the three sine/cosine pairs into the quaternion
// two multiply stages, then sum and saturate
// ---------------------------------------------------------------------------
module e2q_merge (
  input  logic                            clk,
  input  logic signed [e2q_pkg::CW-1:0]   sp, cp, sy, cy, sr, cr,
  output logic signed [e2q_pkg::QUAT_W-1:0] qx, qy, qz, qw
);
  import e2q_pkg::*;

  cw_t crsp, srcp, crcp, srsp;
  cw_t sy1, cy1;
  always_ff @(posedge clk) begin
    crsp <= qmul(cr, sp);
    srcp <= qmul(sr, cp);
    crcp <= qmul(cr, cp);
    srsp <= qmul(sr, sp);
    sy1  <= sy;
    cy1  <= cy;
  end

  cw_t t0, t1, t2, t3, t4, t5, t6, t7;
  always_ff @(posedge clk) begin
    t0 <= qmul(crsp, sy1);
    t1 <= qmul(srcp, cy1);
    t2 <= qmul(crsp, cy1);
    t3 <= qmul(srcp, sy1);
    t4 <= qmul(crcp, sy1);
    t5 <= qmul(srsp, cy1);
    t6 <= qmul(crcp, cy1);
    t7 <= qmul(srsp, sy1);
  end

  always_ff @(posedge clk) begin
    qx <= QUAT_W'(clamp_unit((CW+1)'(t0) - (CW+1)'(t1)));
    qy <= QUAT_W'(clamp_unit(-(CW+1)'(t2) - (CW+1)'(t3)));
    qz <= QUAT_W'(clamp_unit((CW+1)'(t4) - (CW+1)'(t5)));
    qw <= QUAT_W'(clamp_unit((CW+1)'(t6) + (CW+1)'(t7)));
  end

endmodule

### rtl/euler_to_quaternion_unit.sv
// ---------------------------------------------------------------------------
// euler_to_quaternion_unit: pitch/yaw/roll in degrees to a q1.30 quaternion
// done is start carried down a valid shift line as deep as the datapath; one item accepted every cycle
// three lanes (reduction + 30-stage cordic) run in parallel, then a merge
// busy is held low: the pipeline never stalls and the receiver cannot stall
// reset clears only the valid shift line; in-flight items are dropped
// ---------------------------------------------------------------------------
module euler_to_quaternion_unit #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_D
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   pitch_deg,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   yaw_deg,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   roll_deg,
  output logic                                 done,
  output logic signed [e2q_pkg::QUAT_W-1:0]    quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]    quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]    quat_z,
  output logic signed [e2q_pkg::QUAT_W-1:0]    quat_w
);
  import e2q_pkg::*;

  // phase 6 + cordic 31 + merge 3
  localparam int LAT = 6 + CORDIC_STEPS + 1 + 3;

  logic signed [ANGLE_W-1:0] ang [3];
  cw_t ph [3];
  logic fp [3];
  cw_t sn [3];
  cw_t cs [3];

  assign ang[0] = pitch_deg;
  assign ang[1] = yaw_deg;
  assign ang[2] = roll_deg;

  // one lane per angle
  for (genvar l = 0; l < 3; l++) begin : g_lane
    e2q_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase (
      .clk(clk), .angle(ang[l]), .phase(ph[l]), .flip(fp[l])
    );
    e2q_cordic u_cordic (
      .clk(clk), .phase(ph[l]), .flip(fp[l]), .sin_q(sn[l]), .cos_q(cs[l])
    );
  end

  e2q_merge u_merge (
    .clk(clk),
    .sp(sn[0]), .cp(cs[0]), .sy(sn[1]), .cy(cs[1]), .sr(sn[2]), .cr(cs[2]),
    .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
  );

  // valid travels alongside the data
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign busy = 1'b0;
  assign done = vld[LAT-1];

endmodule

### tb/tb_euler_to_quaternion_unit.sv
// ---------------------------------------------------------------------------
// tb_euler_to_quaternion_unit: self-checking bench for the euler to quaternion unit
// drives angle items through the start/busy handshake, predicts each quaternion
// with a bit-exact fixed-point model and checks every done strobe in order
// ---------------------------------------------------------------------------
module tb_euler_to_quaternion_unit;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 900;

  // quaternion expectation for one accepted item
  typedef struct packed {
    logic signed [31:0] qx, qy, qz, qw;
  } quat_t;

  // cordic arctangent table in 2^-32 turn units
  localparam longint ATAN_TURNS [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  localparam longint UNIT = 64'sd1 << 30;

  function automatic longint sat_unit(input longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // q30 product, round to nearest ties up (>>> is floor on signed)
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  // half-angle sine and cosine of one angle in degrees
  function automatic void half_sincos(input logic signed [31:0] deg, output longint s,
                                      output longint c);
    longint a, r, n, mag, p, x, y, z, dx, dy;
    bit flip;
    a = deg;
    r = a % (64'sd360 << FRAC);
    n = r * (64'sd1 << (28 - FRAC));
    mag = (n < 0) ? -n : n;
    p = (mag + 22) / 45;
    if (n < 0) p = -p;
    flip = 0;
    // fold the phase into the cordic range
    if (p > UNIT) begin
      p -= 64'sd1 << 31; flip = 1;
    end else if (p < -UNIT) begin
      p += 64'sd1 << 31; flip = 1;
    end
    x = 64'sd652032874; y = 0; z = p;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = sat_unit(x);
    s = sat_unit(y);
  endfunction

  function automatic quat_t predict_quat(input logic signed [31:0] pd, yd, rd);
    longint sp, cp, sy, cy, sr, cr;
    quat_t q;
    half_sincos(pd, sp, cp);
    half_sincos(yd, sy, cy);
    half_sincos(rd, sr, cr);
    q.qx = 32'(sat_unit(mul_q30(mul_q30(cr, sp), sy) - mul_q30(mul_q30(sr, cp), cy)));
    q.qy = 32'(sat_unit(-mul_q30(mul_q30(cr, sp), cy) - mul_q30(mul_q30(sr, cp), sy)));
    q.qz = 32'(sat_unit(mul_q30(mul_q30(cr, cp), sy) - mul_q30(mul_q30(sr, sp), cy)));
    q.qw = 32'(sat_unit(mul_q30(mul_q30(cr, cp), cy) + mul_q30(mul_q30(sr, sp), sy)));
    return q;
  endfunction

  // in-order scoreboard of pending quaternions
  class quat_scoreboard;
    quat_t pending[$];
    int mismatches = 0;

    function void note_item(logic signed [31:0] pd, yd, rd);
      pending.push_back(predict_quat(pd, yd, rd));
    endfunction

    function void check_result(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("error: unexpected result %0d %0d %0d %0d",
                                       got.qx, got.qy, got.qz, got.qw);
        return;
      end
      exp_q = pending.pop_front();
      if (exp_q != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: quat exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                   exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw,
                   got.qx, got.qy, got.qz, got.qw);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic signed [31:0] pitch_deg = 0, yaw_deg = 0, roll_deg = 0;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  quat_scoreboard sb = new();

  euler_to_quaternion_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pitch_deg(pitch_deg), .yaw_deg(yaw_deg), .roll_deg(roll_deg),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  // 12 unit clock
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // note the item the block takes at this edge, check any result strobe
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(pitch_deg, yaw_deg, roll_deg);
      if (done) sb.check_result('{quat_x, quat_y, quat_z, quat_w});
    end
  end

  // random angle biased toward interesting regions
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 720 << FRAC)) - (360 << FRAC));
      2: return 32'(($urandom_range(0, 1) ? 360 : -360) << FRAC)
                + 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 16)) - 8) * (32'sd45 << FRAC);
      default: return 32'($signed($urandom_range(0, 4000 << FRAC)) - (2000 << FRAC));
    endcase
  endfunction

  // present one item and hold it until the handshake takes it
  task automatic send_item(input logic [31:0] pd, yd, rd, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 15) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    pitch_deg <= pd; yaw_deg <= yd; roll_deg <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] edge_vals [12];
    edge_vals = '{32'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h1,
                  32'(360 << FRAC), 32'(-(360 << FRAC)), 32'(360 << FRAC) - 1,
                  32'(-(360 << FRAC)) + 1, 32'(180 << FRAC), 32'(-(180 << FRAC)),
                  32'(90 << FRAC)};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes on each axis, near plus and minus full turn
    for (int i = 0; i < 12; i++) send_item(edge_vals[i], edge_vals[(i + 5) % 12],
                                           edge_vals[(i + 7) % 12], 1);
    send_item(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_item(32'(360 << FRAC), 32'(-(360 << FRAC)), 32'(360 << FRAC), 1);
    // random; a middle stretch without gaps
    for (int i = 0; i < N_RANDOM; i++)
      send_item(pick_angle(), pick_angle(), pick_angle(), !(i >= 300 && i < 450));
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
